/* src/cmsp_pkg.sv */
// -----------------------------------------------------------------------------
// CoAP stream parser package
// Parse phases, byte kinds, error codes and the shared state and result types.
// -----------------------------------------------------------------------------
package cmsp_pkg;

	typedef enum logic [7:0] {
		PH_HDR  = 8'b0000_0001,
		PH_TOK  = 8'b0000_0010,
		PH_HEAD = 8'b0000_0100,
		PH_DEXT = 8'b0000_1000,
		PH_LEXT = 8'b0001_0000,
		PH_VAL  = 8'b0010_0000,
		PH_PAY  = 8'b0100_0000,
		PH_IGN  = 8'b1000_0000
	} phase_t;

	localparam logic [2:0] KIND_HDR  = 3'd0;
	localparam logic [2:0] KIND_TOK  = 3'd1;
	localparam logic [2:0] KIND_OPT  = 3'd2;
	localparam logic [2:0] KIND_VAL  = 3'd3;
	localparam logic [2:0] KIND_MARK = 3'd4;
	localparam logic [2:0] KIND_PAY  = 3'd5;
	localparam logic [2:0] KIND_IGN  = 3'd6;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_HDR_SHORT = 4'd1;
	localparam logic [3:0] ERR_VERSION   = 4'd2;
	localparam logic [3:0] ERR_CODE      = 4'd3;
	localparam logic [3:0] ERR_TOKEN     = 4'd4;
	localparam logic [3:0] ERR_OPT_SHORT = 4'd5;
	localparam logic [3:0] ERR_DELTA15   = 4'd6;
	localparam logic [3:0] ERR_LEN15     = 4'd7;
	localparam logic [3:0] ERR_OPT_BIG   = 4'd8;

	// held header error
	localparam logic [1:0] PEND_NONE    = 2'd0;
	localparam logic [1:0] PEND_VERSION = 2'd1;
	localparam logic [1:0] PEND_CODE    = 2'd2;

	localparam logic [7:0]  COAP_VERSION_BYTE = 8'h40;
	localparam logic [7:0]  PAYLOAD_MARKER    = 8'hFF;
	localparam logic [3:0]  MAX_TOKEN_LEN     = 4'd8;
	localparam logic [3:0]  NIB_EXT1          = 4'd13;
	localparam logic [3:0]  NIB_RESERVED      = 4'd15;
	localparam logic [3:0]  NIB_EXT_BASE      = 4'd12;
	localparam logic [15:0] EXT1_OFFSET       = 16'd13;
	localparam logic [15:0] EXT2_OFFSET       = 16'd269;
	localparam logic [7:0]  MAX_OPTIONS_RST   = 8'd16;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bcnt;
		logic [1:0]  hdr_type;
		logic [3:0]  hdr_tkl;
		logic [7:0]  hdr_code;
		logic [15:0] hdr_mid;
		logic [1:0]  pend;
		logic [15:0] opt_num;
		logic [3:0]  dnib;
		logic [3:0]  lnib;
		logic [15:0] ext;
		logic [15:0] cur_len;
		logic [15:0] val_rem;
		logic [7:0]  opts;
		logic [3:0]  err;
	} state_t;

	localparam state_t STATE_RST = '{
		phase:    PH_HDR,
		bcnt:     4'd0,
		hdr_type: 2'd0,
		hdr_tkl:  4'd0,
		hdr_code: 8'd0,
		hdr_mid:  16'd0,
		pend:     PEND_NONE,
		opt_num:  16'd0,
		dnib:     4'd0,
		lnib:     4'd0,
		ext:      16'd0,
		cur_len:  16'd0,
		val_rem:  16'd0,
		opts:     8'd0,
		err:      ERR_NONE
	};

	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [7:0]  data_out;
		logic [15:0] option_number;
		logic [15:0] option_length;
		logic [7:0]  option_index;
		logic        value_start;
		logic [3:0]  error_code;
		logic        message_end;
		logic [1:0]  msg_type;
		logic [3:0]  token_length;
		logic [7:0]  msg_code;
		logic [15:0] message_id;
	} result_t;

	// handshake between pipeline stages
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

/* src/cmsp_in_stage.sv */
// -----------------------------------------------------------------------------
// CoAP stream parser input stage
// Registers one input byte and its last flag; frees when the parse step takes it.
// -----------------------------------------------------------------------------
module cmsp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,
	input  logic            s_tlast,
	input  logic            take,
	output cmsp_pkg::hs_t   hs,
	output logic [7:0]      byte_s1,
	output logic            last_s1
);

	logic valid_s1;

	assign s_tready = !valid_s1 || take;
	assign hs.valid = valid_s1;
	assign hs.ready = s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

/* src/cmsp_parser.sv */
// -----------------------------------------------------------------------------
// CoAP stream parser step
// Parse state, max_options register and the one-byte next-state / result logic.
// -----------------------------------------------------------------------------
module cmsp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               step,
	input  logic [7:0]         byte_s1,
	input  logic               last_s1,
	output cmsp_pkg::result_t  res
);

	cmsp_pkg::state_t st_q;
	cmsp_pkg::state_t st_d;
	cmsp_pkg::state_t st_n;
	logic [7:0]  max_opts_q;
	logic [2:0]  kind;
	logic        vs;
	logic        do_lpart;
	logic        do_lknown;
	logic [15:0] ext_new;

	function automatic cmsp_pkg::state_t raise_err(input cmsp_pkg::state_t s,
			input logic [3:0] code);
		cmsp_pkg::state_t r;
		r = s;
		if (r.err == cmsp_pkg::ERR_NONE) begin
			r.err = code;
		end
		r.phase = cmsp_pkg::PH_IGN;
		return r;
	endfunction

	assign ext_new = {st_q.ext[7:0], byte_s1};

	always_comb begin
		st_d      = st_q;
		kind      = cmsp_pkg::KIND_IGN;
		vs        = 1'b0;
		do_lpart  = 1'b0;
		do_lknown = 1'b0;
		case (st_q.phase)
			cmsp_pkg::PH_HDR: begin
				kind = cmsp_pkg::KIND_HDR;
				case (st_q.bcnt)
					4'd0: begin
						st_d.hdr_type = byte_s1[5:4];
						st_d.hdr_tkl  = byte_s1[3:0];
						if (byte_s1[7:6] != cmsp_pkg::COAP_VERSION_BYTE[7:6]) begin
							st_d.pend = cmsp_pkg::PEND_VERSION;
						end
					end
					4'd1: begin
						st_d.hdr_code = byte_s1;
						if (st_q.pend == cmsp_pkg::PEND_NONE && byte_s1[7]) begin
							st_d.pend = cmsp_pkg::PEND_CODE;
						end
					end
					4'd2: st_d.hdr_mid[15:8] = byte_s1;
					default: st_d.hdr_mid[7:0] = byte_s1;
				endcase
				if (st_q.bcnt < 4'd3) begin
					st_d.bcnt = st_q.bcnt + 4'd1;
					if (last_s1) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_HDR_SHORT);
					end
				end else if (st_d.pend != cmsp_pkg::PEND_NONE) begin
					st_d = raise_err(st_d, (st_d.pend == cmsp_pkg::PEND_VERSION) ?
						cmsp_pkg::ERR_VERSION : cmsp_pkg::ERR_CODE);
				end else if (st_d.hdr_tkl > cmsp_pkg::MAX_TOKEN_LEN) begin
					st_d = raise_err(st_d, cmsp_pkg::ERR_TOKEN);
				end else if (st_d.hdr_tkl == 4'd0) begin
					st_d.phase = cmsp_pkg::PH_HEAD;
				end else begin
					st_d.phase = cmsp_pkg::PH_TOK;
					st_d.bcnt  = st_d.hdr_tkl;
					if (last_s1) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_TOKEN);
					end
				end
			end
			cmsp_pkg::PH_TOK: begin
				kind = cmsp_pkg::KIND_TOK;
				if (st_q.bcnt <= 4'd1) begin
					st_d.bcnt  = 4'd0;
					st_d.phase = cmsp_pkg::PH_HEAD;
				end else begin
					st_d.bcnt = st_q.bcnt - 4'd1;
					if (last_s1) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_TOKEN);
					end
				end
			end
			cmsp_pkg::PH_HEAD: begin
				if (byte_s1 == cmsp_pkg::PAYLOAD_MARKER) begin
					kind       = cmsp_pkg::KIND_MARK;
					st_d.phase = cmsp_pkg::PH_PAY;
				end else if (st_q.opts >= max_opts_q) begin
					kind       = cmsp_pkg::KIND_IGN;
					st_d.phase = cmsp_pkg::PH_IGN;
				end else begin
					kind         = cmsp_pkg::KIND_OPT;
					st_d.dnib    = byte_s1[7:4];
					st_d.lnib    = byte_s1[3:0];
					st_d.cur_len = 16'd0;
					if (byte_s1[7:4] == cmsp_pkg::NIB_RESERVED) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_DELTA15);
					end else if (byte_s1[7:4] >= cmsp_pkg::NIB_EXT1) begin
						st_d.bcnt  = byte_s1[7:4] - cmsp_pkg::NIB_EXT_BASE;
						st_d.ext   = 16'd0;
						st_d.phase = cmsp_pkg::PH_DEXT;
						if (last_s1) begin
							st_d = raise_err(st_d, cmsp_pkg::ERR_OPT_SHORT);
						end
					end else begin
						st_d.opt_num = st_q.opt_num + {12'd0, byte_s1[7:4]};
						do_lpart     = 1'b1;
					end
				end
			end
			cmsp_pkg::PH_DEXT: begin
				kind     = cmsp_pkg::KIND_OPT;
				st_d.ext = ext_new;
				if (st_q.bcnt <= 4'd1) begin
					st_d.bcnt    = 4'd0;
					st_d.opt_num = st_q.opt_num + ext_new +
						((st_q.dnib == cmsp_pkg::NIB_EXT1) ?
						cmsp_pkg::EXT1_OFFSET : cmsp_pkg::EXT2_OFFSET);
					do_lpart     = 1'b1;
				end else begin
					st_d.bcnt = st_q.bcnt - 4'd1;
					if (last_s1) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_OPT_SHORT);
					end
				end
			end
			cmsp_pkg::PH_LEXT: begin
				kind     = cmsp_pkg::KIND_OPT;
				st_d.ext = ext_new;
				if (st_q.bcnt <= 4'd1) begin
					st_d.bcnt    = 4'd0;
					st_d.cur_len = ext_new + ((st_q.lnib == cmsp_pkg::NIB_EXT1) ?
						cmsp_pkg::EXT1_OFFSET : cmsp_pkg::EXT2_OFFSET);
					do_lknown    = 1'b1;
				end else begin
					st_d.bcnt = st_q.bcnt - 4'd1;
					if (last_s1) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_OPT_SHORT);
					end
				end
			end
			cmsp_pkg::PH_VAL: begin
				kind = cmsp_pkg::KIND_VAL;
				vs   = (st_q.val_rem == st_q.cur_len);
				if (st_q.val_rem <= 16'd1) begin
					st_d.val_rem = 16'd0;
					st_d.opts    = st_q.opts + 8'd1;
					st_d.phase   = cmsp_pkg::PH_HEAD;
				end else begin
					st_d.val_rem = st_q.val_rem - 16'd1;
					if (last_s1) begin
						st_d = raise_err(st_d, cmsp_pkg::ERR_OPT_BIG);
					end
				end
			end
			cmsp_pkg::PH_PAY: kind = cmsp_pkg::KIND_PAY;
			default: kind = cmsp_pkg::KIND_IGN;
		endcase

		// length nibble, after the delta is complete
		if (do_lpart) begin
			if (st_d.lnib == cmsp_pkg::NIB_RESERVED) begin
				st_d = raise_err(st_d, cmsp_pkg::ERR_LEN15);
			end else if (st_d.lnib >= cmsp_pkg::NIB_EXT1) begin
				st_d.bcnt  = st_d.lnib - cmsp_pkg::NIB_EXT_BASE;
				st_d.ext   = 16'd0;
				st_d.phase = cmsp_pkg::PH_LEXT;
				if (last_s1) begin
					st_d = raise_err(st_d, cmsp_pkg::ERR_OPT_SHORT);
				end
			end else begin
				st_d.cur_len = {12'd0, st_d.lnib};
				do_lknown    = 1'b1;
			end
		end

		if (do_lknown) begin
			if (st_d.cur_len == 16'd0) begin
				vs         = 1'b1;
				st_d.opts  = st_d.opts + 8'd1;
				st_d.phase = cmsp_pkg::PH_HEAD;
			end else begin
				st_d.val_rem = st_d.cur_len;
				st_d.phase   = cmsp_pkg::PH_VAL;
				if (last_s1) begin
					st_d = raise_err(st_d, cmsp_pkg::ERR_OPT_BIG);
				end
			end
		end

		st_n = last_s1 ? cmsp_pkg::STATE_RST : st_d;
	end

	always_comb begin
		res.byte_kind     = kind;
		res.data_out      = byte_s1;
		res.option_number = st_d.opt_num;
		res.option_length = st_d.cur_len;
		res.option_index  = st_q.opts;
		res.value_start   = vs;
		res.error_code    = st_d.err;
		res.message_end   = last_s1;
		res.msg_type      = st_d.hdr_type;
		res.token_length  = st_d.hdr_tkl;
		res.msg_code      = st_d.hdr_code;
		res.message_id    = st_d.hdr_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cmsp_pkg::STATE_RST;
		end else if (step) begin
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_opts_q <= cmsp_pkg::MAX_OPTIONS_RST;
		end else if (cfg_we) begin
			max_opts_q <= cfg_wdata;
		end
	end

endmodule

/* src/cmsp_out_stage.sv */
// -----------------------------------------------------------------------------
// CoAP stream parser result stage
// Holds one result until the downstream side takes it.
// -----------------------------------------------------------------------------
module cmsp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  cmsp_pkg::result_t  res,
	input  logic               m_tready,
	output cmsp_pkg::hs_t      hs,
	output cmsp_pkg::result_t  res_q
);

	logic valid_q;

	// can take a new result when empty or being drained this cycle
	assign hs.ready = !valid_q || m_tready;
	assign hs.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hs.ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && hs.ready) begin
			res_q <= res;
		end
	end

endmodule

/* src/coap_message_stream_parser_top.sv */
// -----------------------------------------------------------------------------
// CoAP message stream parser
// Path: each accepted byte is registered in the input stage, parsed by one pass of logic, then registered.
// Throughput: one byte per cycle while the downstream side keeps m_tready high.
// Reset (arst_n low, asynchronous): both stages empty, parse state at header byte 0,
// max_options back to 16.
// -----------------------------------------------------------------------------
module coap_message_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// data_out[7:0], option_number[23:8], option_length[39:24], option_index[47:40],
	// value_start[48], error_code[52:49], msg_type[54:53], token_length[58:55],
	// msg_code[66:59], message_id[82:67], zero fill[87:83]
	output logic [87:0] m_tdata,
	output logic [2:0]  m_tuser,   // byte_kind
	output logic        m_tlast    // message_end
);

	cmsp_pkg::hs_t     in_hs;
	cmsp_pkg::hs_t     out_hs;
	cmsp_pkg::result_t res;
	cmsp_pkg::result_t res_q;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              step;

	assign step = in_hs.valid && out_hs.ready;

	cmsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (step),
		.hs       (in_hs),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	cmsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1),
		.res       (res)
	);

	cmsp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.m_tready (m_tready),
		.hs       (out_hs),
		.res_q    (res_q)
	);

	assign m_tvalid = out_hs.valid;
	assign m_tuser  = res_q.byte_kind;
	assign m_tlast  = res_q.message_end;
	assign m_tdata  = {5'd0, res_q.message_id, res_q.msg_code, res_q.token_length,
		res_q.msg_type, res_q.error_code, res_q.value_start, res_q.option_index,
		res_q.option_length, res_q.option_number, res_q.data_out};

`ifndef SYNTHESIS
	// value start only on option and option-value bytes
	a_vs_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[48]) |->
		(m_tuser == cmsp_pkg::KIND_OPT || m_tuser == cmsp_pkg::KIND_VAL))
		else $error("value_start outside option bytes");

	// payload is only reached on an error-free message
	a_pay_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == cmsp_pkg::KIND_PAY) |-> (m_tdata[52:49] == cmsp_pkg::ERR_NONE))
		else $error("payload byte with latched error");

	// header and token bytes come before any option
	a_hdr_noopt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == cmsp_pkg::KIND_HDR || m_tuser == cmsp_pkg::KIND_TOK)) |->
		(m_tdata[23:8] == 16'd0 && m_tdata[47:40] == 8'd0))
		else $error("option state set during header or token");

	// a step always lands in the result register next cycle
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid)
		else $error("parsed byte lost");
`endif

endmodule
